// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operation codes, sequencer states, the default operand width and the control
// and status groups passed between the sequencer and the shared divider.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int unsigned WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_SUM,
		ST_GCD,
		ST_GCD_WAIT,
		ST_NDIV,
		ST_NDIV_WAIT,
		ST_DDIV,
		ST_DDIV_WAIT,
		ST_PACK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ----- rtl/rational_arith_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arith_unit: rational add, subtract, multiply and divide
// Exact cross products, Euclidean gcd reduction, overflow to 0/1.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid in_ready kind a_num a_den b_num b_den | into block
//  out     | out_valid out_ready res_num res_den overflow  | out of block
//
//  one transaction at a time; gcd reduction runs on the shared bit-serial
//  divider (2*WIDTH+1 bits a pass).
//  in_ready is high only when idle; the result holds until out_ready.
//  arst_n clears the sequencer; datapath registers need no reset.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
	parameter int unsigned WIDTH = rau_pkg::WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] a_num,
	input  logic [31:0] a_den,
	input  logic [31:0] b_num,
	input  logic [31:0] b_den,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] res_num,
	output logic [30:0] res_den,
	output logic        overflow
);

	rau_seq #(.WIDTH(WIDTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.a_num     (a_num),
		.a_den     (a_den),
		.b_num     (b_num),
		.b_den     (b_den),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_num   (res_num),
		.res_den   (res_den),
		.overflow  (overflow)
	);

endmodule

// ----- rtl/rau_div.sv -----
// ----------------------------------------------------------------------------
// rau_div: shared restoring divider
// Unsigned divide of a DW-bit dividend by a DW-bit divisor, one quotient
// bit per cycle; quotient and remainder held until the next start.
// ----------------------------------------------------------------------------
module rau_div #(
	parameter int unsigned DW = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rau_pkg::div_ctl_t ctl,
	input  logic [DW-1:0]    dividend,
	input  logic [DW-1:0]    divisor,
	output rau_pkg::div_sts_t sts,
	output logic [DW-1:0]    quot,
	output logic [DW-1:0]    rem
);

	localparam int unsigned CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW-1:0] q_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] d_q;
	logic [DW:0]   r_sh;
	logic [DW:0]   r_sub;

	assign r_sh  = {r_q, q_q[DW-1]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				cnt_q  <= CW'(DW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!r_sub[DW]) begin
				r_q <= r_sub[DW-1:0];
				q_q <= {q_q[DW-2:0], 1'b1};
			end else begin
				r_q <= r_sh[DW-1:0];
				q_q <= {q_q[DW-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = q_q;
	assign rem      = r_q;

endmodule

// ----- rtl/rau_seq.sv -----
// ----------------------------------------------------------------------------
// rau_seq: operand datapath and sequencer
// Forms the cross products one per cycle, combines them, runs Euclid on the
// shared divider and divides both magnitudes by the gcd unless one is zero.
// ----------------------------------------------------------------------------
module rau_seq #(
	parameter int unsigned WIDTH = rau_pkg::WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] a_num,
	input  logic [31:0] a_den,
	input  logic [31:0] b_num,
	input  logic [31:0] b_den,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] res_num,
	output logic [30:0] res_den,
	output logic        overflow
);

	localparam int unsigned DW = 2 * WIDTH + 1;
	localparam int unsigned MW = 2 * WIDTH;

	rau_pkg::state_t  state_q, state_nx;
	rau_pkg::div_ctl_t dctl;
	rau_pkg::div_sts_t dsts;

	logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic             ann_q, adn_q, bnn_q, bdn_q;
	logic [1:0]       kind_q;
	logic [MW-1:0]    p0_q, p1_q;
	logic             p0n_q, p1n_q;
	logic [DW-1:0]    nm_q, dm_q, x_q, y_q, g_q;
	logic             nn_q, dn_q;
	logic [DW-1:0]    div_a, div_b, quot, rem;
	logic [WIDTH-1:0] mul_x, mul_y;
	logic             mul_n;
	logic [MW-1:0]    prod;
	logic [DW-1:0]    q_n_q;
	logic [31:0]      rnum_q;
	logic [30:0]      rden_q;
	logic             ovf_q;
	logic [31:0]      nm32;

	function automatic logic [WIDTH:0] mag(input logic [WIDTH-1:0] v);
		logic [WIDTH:0] m;
		m = v[WIDTH-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
		return m;
	endfunction

	// one shared multiplier, operands steered by state
	always_comb begin
		mul_x = an_q;
		mul_y = bd_q;
		mul_n = ann_q ^ bdn_q;
		case (state_q)
			rau_pkg::ST_MUL0: begin
				mul_x = an_q;
				mul_y = (kind_q == rau_pkg::OP_MUL) ? bn_q : bd_q;
				mul_n = ann_q ^ ((kind_q == rau_pkg::OP_MUL) ? bnn_q : bdn_q);
			end
			rau_pkg::ST_MUL1: begin
				mul_x = ad_q;
				mul_y = (kind_q == rau_pkg::OP_DIV) ? bn_q : bd_q;
				mul_n = adn_q ^ ((kind_q == rau_pkg::OP_DIV) ? bnn_q : bdn_q);
			end
			rau_pkg::ST_MUL2: begin
				mul_x = ad_q;
				mul_y = bn_q;
				mul_n = adn_q ^ bnn_q ^ (kind_q == rau_pkg::OP_SUB);
			end
			default: ;
		endcase
	end
	assign prod = MW'(mul_x) * MW'(mul_y);

	always_comb begin
		div_a = x_q;
		div_b = y_q;
		case (state_q)
			rau_pkg::ST_NDIV: begin div_a = nm_q; div_b = g_q; end
			rau_pkg::ST_DDIV: begin div_a = dm_q; div_b = g_q; end
			default: ;
		endcase
	end
	assign dctl.start = (state_q == rau_pkg::ST_GCD && y_q != '0) ||
		state_q == rau_pkg::ST_NDIV || state_q == rau_pkg::ST_DDIV;

	rau_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dctl),
		.dividend (div_a),
		.divisor  (div_b),
		.sts      (dsts),
		.quot     (quot),
		.rem      (rem)
	);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			rau_pkg::ST_IDLE:  if (in_valid) state_nx = rau_pkg::ST_MUL0;
			rau_pkg::ST_MUL0:  state_nx = rau_pkg::ST_MUL1;
			rau_pkg::ST_MUL1:  state_nx = (kind_q == rau_pkg::OP_ADD ||
				kind_q == rau_pkg::OP_SUB) ? rau_pkg::ST_MUL2 : rau_pkg::ST_SUM;
			rau_pkg::ST_MUL2:  state_nx = rau_pkg::ST_SUM;
			rau_pkg::ST_SUM:   state_nx = (nm_q == '0 || dm_q == '0) ?
				rau_pkg::ST_PACK : rau_pkg::ST_GCD;
			rau_pkg::ST_GCD:   state_nx = (y_q == '0) ? rau_pkg::ST_NDIV :
				rau_pkg::ST_GCD_WAIT;
			rau_pkg::ST_GCD_WAIT:  if (dsts.done) state_nx = rau_pkg::ST_GCD;
			rau_pkg::ST_NDIV:      state_nx = rau_pkg::ST_NDIV_WAIT;
			rau_pkg::ST_NDIV_WAIT: if (dsts.done) state_nx = rau_pkg::ST_DDIV;
			rau_pkg::ST_DDIV:      state_nx = rau_pkg::ST_DDIV_WAIT;
			rau_pkg::ST_DDIV_WAIT: if (dsts.done) state_nx = rau_pkg::ST_PACK;
			rau_pkg::ST_PACK:  state_nx = rau_pkg::ST_OUT;
			rau_pkg::ST_OUT:   if (out_ready) state_nx = rau_pkg::ST_IDLE;
			default:           state_nx = rau_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == rau_pkg::ST_IDLE);
		out_valid = (state_q == rau_pkg::ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rau_pkg::ST_IDLE;
		else         state_q <= state_nx;
	end

	logic [WIDTH:0] m_an, m_ad, m_bn, m_bd;
	assign m_an = mag(a_num[WIDTH-1:0]);
	assign m_ad = mag(a_den[WIDTH-1:0]);
	assign m_bn = mag(b_num[WIDTH-1:0]);
	assign m_bd = mag(b_den[WIDTH-1:0]);

	logic [WIDTH:0] lim;
	assign lim = {2'b00, {(WIDTH-1){1'b1}}};

	assign nm32 = 32'(nm_q);

	always_ff @(posedge clk) begin
		case (state_q)
			rau_pkg::ST_IDLE: begin
				kind_q <= kind;
				// the most negative value keeps its full magnitude in WIDTH bits
				an_q <= m_an[WIDTH-1:0]; ann_q <= a_num[WIDTH-1];
				ad_q <= m_ad[WIDTH-1:0]; adn_q <= a_den[WIDTH-1];
				bn_q <= m_bn[WIDTH-1:0]; bnn_q <= b_num[WIDTH-1];
				bd_q <= m_bd[WIDTH-1:0]; bdn_q <= b_den[WIDTH-1];
			end
			rau_pkg::ST_MUL0: begin p0_q <= prod; p0n_q <= mul_n; end
			rau_pkg::ST_MUL1: begin
				dm_q <= {1'b0, prod}; dn_q <= mul_n;
				if (kind_q == rau_pkg::OP_MUL || kind_q == rau_pkg::OP_DIV) begin
					nm_q <= {1'b0, p0_q}; nn_q <= p0n_q;
				end
			end
			rau_pkg::ST_MUL2: begin
				if (p0n_q == mul_n) begin
					nm_q <= {1'b0, p0_q} + {1'b0, prod}; nn_q <= p0n_q;
				end else if (p0_q >= prod) begin
					nm_q <= {1'b0, p0_q - prod}; nn_q <= p0n_q;
				end else begin
					nm_q <= {1'b0, prod - p0_q}; nn_q <= mul_n;
				end
			end
			rau_pkg::ST_SUM: begin x_q <= nm_q; y_q <= dm_q; end
			rau_pkg::ST_GCD: if (y_q == '0) g_q <= x_q;
			rau_pkg::ST_GCD_WAIT: if (dsts.done) begin x_q <= y_q; y_q <= rem; end
			rau_pkg::ST_NDIV_WAIT: if (dsts.done) q_n_q <= quot;
			rau_pkg::ST_DDIV_WAIT: if (dsts.done) begin
				nm_q <= q_n_q; dm_q <= quot;
			end
			rau_pkg::ST_PACK: begin
				if (nm_q == '0 || dm_q == '0) begin
					rnum_q <= '0; rden_q <= 31'd1; ovf_q <= 1'b0;
				end else if (nm_q > DW'(lim) || dm_q > DW'(lim)) begin
					rnum_q <= '0; rden_q <= 31'd1; ovf_q <= 1'b1;
				end else begin
					rnum_q <= (nn_q ^ dn_q) ? (32'd0 - nm32) : nm32;
					rden_q <= 31'(dm_q);
					ovf_q  <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign res_num  = rnum_q;
	assign res_den  = rden_q;
	assign overflow = ovf_q;

endmodule

// ----- rtl/rau_chk.sv -----
// ----------------------------------------------------------------------------
// rau_chk: port-level checks for the rational arithmetic unit
// Watches handshakes and result encoding on the top level.
// ----------------------------------------------------------------------------
module rau_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] res_num,
	input logic [30:0] res_den,
	input logic        overflow
);

	// never accept and present a result at once
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");

	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> res_den != '0) else $error("zero denominator");

	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> (res_num == '0 && res_den == 31'd1))
		else $error("overflow result not 0/1");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(res_num)))
		else $error("result dropped");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("ready after accept");

endmodule

bind rational_arith_unit rau_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.res_num   (res_num),
	.res_den   (res_den),
	.overflow  (overflow)
);

// ----- tb/sv/rational_arith_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arith_unit_tb: self-checking bench for the rational arithmetic unit
// Directed corner operands and then random rationals are sent under random
// sender bursts and receiver stalls. An exact gcd-reduction predictor builds
// the expected results, and a scoreboard checks each result in order.
// ----------------------------------------------------------------------------
module rational_arith_unit_tb;

	localparam int W = 32;
	localparam int WATCHDOG_LIMIT = 50000;
	localparam int N_RANDOM = 1880;

	typedef struct {
		logic [31:0] num;
		logic [30:0] den;
		logic        ovf;
	} ratio_t;

	int unsigned errors = 0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h", what, got, want);
	endtask

	// exact rational result, reduced by gcd
	function automatic ratio_t reduce_ratio(input rau_pkg::op_t op, input logic [31:0] an,
			input logic [31:0] ad, input logic [31:0] bn, input logic [31:0] bd);
		logic signed [127:0] n, d;
		logic [127:0] nm, dm, x, y, t, g;
		logic neg;
		ratio_t r;
		r.num = '0;
		r.den = 31'd1;
		r.ovf = 1'b0;
		case (op)
			rau_pkg::OP_ADD: begin
				n = $signed(an) * $signed(bd) + $signed(ad) * $signed(bn);
				d = $signed(ad) * $signed(bd);
			end
			rau_pkg::OP_SUB: begin
				n = $signed(an) * $signed(bd) - $signed(ad) * $signed(bn);
				d = $signed(ad) * $signed(bd);
			end
			rau_pkg::OP_MUL: begin
				n = $signed(an) * $signed(bn);
				d = $signed(ad) * $signed(bd);
			end
			default: begin
				n = $signed(an) * $signed(bd);
				d = $signed(ad) * $signed(bn);
			end
		endcase
		if (n == 0 || d == 0)
			return r;
		neg = (n < 0) != (d < 0);
		nm = (n < 0) ? -n : n;
		dm = (d < 0) ? -d : d;
		x = nm;
		y = dm;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		g = x;
		nm = nm / g;
		dm = dm / g;
		if (nm > 128'h7fffffff || dm > 128'h7fffffff) begin
			r.ovf = 1'b1;
			return r;
		end
		r.num = neg ? -nm[31:0] : nm[31:0];
		r.den = dm[30:0];
		return r;
	endfunction

	class ratio_scoreboard;
		ratio_t pending[$];

		function void note_input(rau_pkg::op_t op, logic [31:0] an, logic [31:0] ad,
				logic [31:0] bn, logic [31:0] bd);
			pending.push_back(reduce_ratio(op, an, ad, bn, bd));
		endfunction

		task check_result(logic [31:0] num, logic [30:0] den, logic ovf);
			ratio_t e;
			if (pending.size() == 0) begin
				report("unexpected result", {num, 1'b0, den}, 0);
				return;
			end
			e = pending.pop_front();
			if (num !== e.num) report("res_num", num, e.num);
			if (den !== e.den) report("res_den", den, e.den);
			if (ovf !== e.ovf) report("overflow", ovf, e.ovf);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = '0;
	logic [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] res_num;
	logic [30:0] res_den;
	logic overflow;

	ratio_scoreboard sb = new();
	bit stall_long = 0;
	int unsigned idle_cycles = 0;

	rational_arith_unit #(.WIDTH(W)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_ready(out_ready),
		.res_num(res_num), .res_den(res_den), .overflow(overflow)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_input(rau_pkg::op_t'(kind), a_num, a_den, b_num, b_den);
		if (out_valid && out_ready)
			sb.check_result(res_num, res_den, overflow);
	end

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver stall pattern, with one long hold-off
	initial begin
		int unsigned phase;
		phase = 0;
		forever begin
			@(posedge clk);
			phase++;
			if (stall_long)
				out_ready <= 1'b0;
			else if (phase % 512 < 128)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic send(input rau_pkg::op_t op, input logic [31:0] an,
			input logic [31:0] ad, input logic [31:0] bn, input logic [31:0] bd);
		in_valid <= 1'b1;
		kind <= op;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 20) - 10;
			1: return $urandom_range(0, 2000) - 1000;
			2: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
			3: return $urandom_range(0, 65535) - 32768;
			default: return $urandom();
		endcase
	endfunction

	task automatic pause_drain();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned burst;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		send(rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
		send(rau_pkg::OP_MUL, 32'd6, 32'd4, 32'd2, 32'd9);
		send(rau_pkg::OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
		send(rau_pkg::OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
		send(rau_pkg::OP_MUL, 32'd0, 32'd7, 32'd5, 32'd3);
		send(rau_pkg::OP_DIV, -32'sd3, 32'd4, 32'd5, -32'sd7);
		send(rau_pkg::OP_MUL, 32'd3, -32'sd4, -32'sd5, -32'sd7);
		send(rau_pkg::OP_ADD, 32'h80000000, 32'd1, 32'h80000000, 32'd1);
		send(rau_pkg::OP_MUL, 32'h80000000, 32'd1, 32'h80000000, 32'd1);
		send(rau_pkg::OP_DIV, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		send(rau_pkg::OP_MUL, 32'h7fffffff, 32'd1, 32'h7fffffff, 32'd1);
		send(rau_pkg::OP_SUB, 32'h7fffffff, 32'h7ffffffe, 32'h80000000, 32'h7fffffff);
		send(rau_pkg::OP_ADD, 32'hffffffff, 32'hffffffff, 32'h55555555, 32'haaaaaaab);
		send(rau_pkg::OP_DIV, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
		send(rau_pkg::OP_SUB, 32'h80000000, 32'd1, 32'd1, 32'd1);
		in_valid <= 1'b0;
		pause_drain();

		// long receiver hold-off while the sender keeps offering
		stall_long = 1;
		fork
			begin
				repeat (3000) @(posedge clk);
				stall_long = 0;
			end
			repeat (4) send(rau_pkg::op_t'($urandom_range(0, 3)), rand_val(), rand_val(),
				rand_val(), rand_val());
		join
		in_valid <= 1'b0;
		pause_drain();

		for (int i = 0; i < N_RANDOM; ) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst && i < N_RANDOM; k++, i++)
				send(rau_pkg::op_t'($urandom_range(0, 3)), rand_val(), rand_val(),
					rand_val(), rand_val());
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 600)) @(posedge clk);
			if (i % 400 == 0) pause_drain();
		end
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
